// ----- rtl/pwa_pkg.sv -----
package pwa_pkg;

   localparam int DATA_W    = 32;
   localparam int GAIN_W    = 32;
   localparam int LIMIT_W   = 31;
   localparam int STEP_W    = 24;
   localparam int INTEG_W   = 48;
   localparam int SUM_W     = 58;
   localparam int CSR_IDX_W = 3;
   localparam int CS_W      = 2;

   localparam int P_SHIFT     = 16;
   localparam int I_SHIFT     = 24;
   localparam int DRIVE_SHIFT = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TIME   = 3'd4;

   localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 32'd26843546;
   localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = 32'd2516582;
   localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 32'd1677722;
   localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = 31'd360448;
   localparam logic [STEP_W-1:0]  STEP_TIME_RST   = 24'd167772;

   localparam logic OP_COMPUTE = 1'b0;
   localparam logic OP_CLEAR   = 1'b1;

   localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum logic [CS_W-1:0] {
      CLAMP_NONE = 2'd0,
      CLAMP_HIGH = 2'd1,
      CLAMP_LOW  = 2'd2
   } clamp_type;

endpackage

// ----- rtl/pwa_ser_mul.sv -----
module pwa_ser_mul #(
   parameter int A_W = 32,
   parameter int B_W = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [A_W-1:0]     a_in,
   input  logic [B_W-1:0]     b_in,
   output logic [A_W+B_W-1:0] product,
   output logic               done
);

   localparam int CNT_W = $clog2(B_W);

   logic [A_W:0]     hi_ff, hi_in;
   logic [B_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic             last_bit;
   logic [A_W+1:0]   a_ext;
   logic [A_W+1:0]   addend;
   logic [A_W+1:0]   sum;

   // signed shift-add, one multiplier bit per cycle, sign bit weighs negative
   always_comb begin
      last_bit = (cnt_ff == CNT_W'(B_W - 1));
      a_ext    = {{2{a_in[A_W-1]}}, a_in};
      if (!lo_ff[0]) begin
         addend = '0;
      end else if (last_bit) begin
         addend = -a_ext;
      end else begin
         addend = a_ext;
      end
      sum = {hi_ff[A_W], hi_ff} + addend;

      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         hi_in   = '0;
         lo_in   = b_in;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         hi_in  = sum[A_W+1:1];
         lo_in  = {sum[0], lo_ff[B_W-1:1]};
         cnt_in = cnt_ff + CNT_W'(1);
         if (last_bit) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign product = {hi_ff[A_W-1:0], lo_ff};
   assign done    = done_ff;

endmodule

// ----- rtl/pwa_ser_div.sv -----
module pwa_ser_div import pwa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [STEP_W-1:0] divisor,
   output logic [DATA_W-1:0] quot,
   output logic              ovf,
   output logic              done
);

   localparam int DIV_STEPS = DATA_W + STEP_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   logic [DATA_W-1:0] num_ff, num_in;
   logic [STEP_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quot_ff, quot_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [STEP_W:0]   trial;
   logic [STEP_W:0]   trial_sub;
   logic              ge;

   // restoring division of dividend * 2^STEP_W, one quotient bit per cycle
   always_comb begin
      trial     = {rem_ff, num_ff[DATA_W-1]};
      trial_sub = trial - {1'b0, divisor};
      ge        = (trial >= {1'b0, divisor});

      num_in  = num_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         quot_in = '0;
         ovf_in  = 1'b0;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         num_in  = {num_ff[DATA_W-2:0], 1'b0};
         rem_in  = ge ? trial_sub[STEP_W-1:0] : trial[STEP_W-1:0];
         quot_in = {quot_ff[DATA_W-2:0], ge};
         ovf_in  = ovf_ff | quot_ff[DATA_W-1];
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      ovf_ff  <= ovf_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quot = quot_ff;
   assign ovf  = ovf_ff;
   assign done = done_ff;

endmodule

// ----- rtl/pid_with_antiwindup.sv -----
// channel | direction | tdata / data          | tuser / index
// req     | in        | error_in [31:0]       | operation [0]
// rsp     | out       | drive [31:0]          | clamp_state [1:0]
// csr     | in        | register value [31:0] | register index [2:0]
//
// from acceptance to rsp_tvalid, a compute transaction runs the 56-step serial
// divider for the derivative followed by the 32-step serial multiplier for the
// derivative term
// a clear transaction is handled in the idle state and gives no response
// reset is synchronous; it loads the register defaults and zeroes the kept state
// a stalled response holds its register; the next request is taken meanwhile

module pid_with_antiwindup import pwa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_W-1:0]    req_tdata,   // error_in
   input  logic [0:0]           req_tuser,   // operation

   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_W-1:0]    rsp_tdata,   // drive
   output logic [CS_W-1:0]      rsp_tuser,   // clamp_state

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data
);

   localparam int PI_W  = DATA_W + STEP_W + 1;
   localparam int INC_W = PI_W - P_SHIFT;
   localparam int PP_W  = GAIN_W + DATA_W;
   localparam int PT_W  = PP_W - P_SHIFT;
   localparam int IP_W  = GAIN_W + INTEG_W;
   localparam int IT_W  = IP_W - I_SHIFT;

   typedef enum logic [9:0] {
      S_IDLE     = 10'b0000000001,
      S_LOAD     = 10'b0000000010,
      S_WAIT_INT = 10'b0000000100,
      S_INTEG    = 10'b0000001000,
      S_WAIT_DIV = 10'b0000010000,
      S_DERIV    = 10'b0000100000,
      S_WAIT_MUL = 10'b0001000000,
      S_SUM_A    = 10'b0010000000,
      S_SUM_B    = 10'b0100000000,
      S_CLAMP    = 10'b1000000000
   } state_type;

   state_type           state_ff, state_in;

   logic [GAIN_W-1:0]   kp_ff, kp_in;
   logic [GAIN_W-1:0]   ki_ff, ki_in;
   logic [GAIN_W-1:0]   kd_ff, kd_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   logic [DATA_W-1:0]   err_ff, err_in;
   logic [DATA_W-1:0]   last_err_ff, last_err_in;
   logic [INTEG_W-1:0]  integ_ff, integ_in;
   logic [INTEG_W-1:0]  integ_old_ff, integ_old_in;
   logic                diff_neg_ff, diff_neg_in;
   logic                diff_zero_ff, diff_zero_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_drive_ff, rsp_drive_in;
   logic [CS_W-1:0]     rsp_clamp_ff, rsp_clamp_in;

   logic [DATA_W:0]     diff;
   logic [DATA_W-1:0]   diff_mag;
   logic [INC_W-1:0]    inc;
   logic [INTEG_W:0]    integ_sum;
   logic [INTEG_W-1:0]  integ_next;
   logic                deriv_sat;
   logic [DATA_W-1:0]   deriv_val;
   logic [SUM_W-1:0]    lim_pos;
   logic [SUM_W-1:0]    lim_neg;
   logic [DATA_W-1:0]   drive_hi;

   logic                start_a;
   logic                start_i;
   logic                start_d;

   logic [PI_W-1:0]     prod_int;
   logic [PP_W-1:0]     prod_p;
   logic [IP_W-1:0]     prod_i;
   logic [PP_W-1:0]     prod_d;
   logic                int_done, p_done, i_done, d_done;
   logic [DATA_W-1:0]   div_quot;
   logic                div_ovf, div_done;

   logic [PT_W-1:0]     p_term;
   logic [IT_W-1:0]     i_term;
   logic [PT_W-1:0]     d_term;

   assign start_a = (state_ff == S_LOAD);
   assign start_i = (state_ff == S_INTEG);
   assign start_d = (state_ff == S_DERIV);

   pwa_ser_mul #(.A_W(DATA_W), .B_W(STEP_W + 1)) u_mul_int (
      .clock   (clock),
      .reset   (reset),
      .start   (start_a),
      .a_in    (err_ff),
      .b_in    ({1'b0, step_ff}),
      .product (prod_int),
      .done    (int_done)
   );

   pwa_ser_mul #(.A_W(GAIN_W), .B_W(DATA_W)) u_mul_p (
      .clock   (clock),
      .reset   (reset),
      .start   (start_a),
      .a_in    (kp_ff),
      .b_in    (err_ff),
      .product (prod_p),
      .done    (p_done)
   );

   pwa_ser_mul #(.A_W(GAIN_W), .B_W(INTEG_W)) u_mul_i (
      .clock   (clock),
      .reset   (reset),
      .start   (start_i),
      .a_in    (ki_ff),
      .b_in    (integ_next),
      .product (prod_i),
      .done    (i_done)
   );

   pwa_ser_mul #(.A_W(GAIN_W), .B_W(DATA_W)) u_mul_d (
      .clock   (clock),
      .reset   (reset),
      .start   (start_d),
      .a_in    (kd_ff),
      .b_in    (deriv_val),
      .product (prod_d),
      .done    (d_done)
   );

   pwa_ser_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_a),
      .dividend (diff_mag),
      .divisor  (step_ff),
      .quot     (div_quot),
      .ovf      (div_ovf),
      .done     (div_done)
   );

   always_comb begin
      diff     = {err_ff[DATA_W-1], err_ff} - {last_err_ff[DATA_W-1], last_err_ff};
      diff_mag = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];

      inc       = prod_int[PI_W-1:P_SHIFT];
      integ_sum = {integ_ff[INTEG_W-1], integ_ff}
                + {{(INTEG_W + 1 - INC_W){inc[INC_W-1]}}, inc};
      if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
         integ_next = {integ_sum[INTEG_W], {(INTEG_W-1){~integ_sum[INTEG_W]}}};
      end else begin
         integ_next = integ_sum[INTEG_W-1:0];
      end

      deriv_sat = div_ovf | div_quot[DATA_W-1];
      if (diff_zero_ff) begin
         deriv_val = '0;
      end else if (!diff_neg_ff) begin
         deriv_val = deriv_sat ? DATA_MAX : div_quot;
      end else begin
         deriv_val = deriv_sat ? DATA_MIN : -div_quot;
      end

      p_term = prod_p[PP_W-1:P_SHIFT];
      i_term = prod_i[IP_W-1:I_SHIFT];
      d_term = prod_d[PP_W-1:P_SHIFT];

      lim_pos  = {{(SUM_W - LIMIT_W - DRIVE_SHIFT){1'b0}}, limit_ff, {DRIVE_SHIFT{1'b0}}};
      lim_neg  = -lim_pos;
      drive_hi = {1'b0, limit_ff};
   end

   always_comb begin
      state_in     = state_ff;
      kp_in        = kp_ff;
      ki_in        = ki_ff;
      kd_in        = kd_ff;
      limit_in     = limit_ff;
      step_in      = step_ff;
      err_in       = err_ff;
      last_err_in  = last_err_ff;
      integ_in     = integ_ff;
      integ_old_in = integ_old_ff;
      diff_neg_in  = diff_neg_ff;
      diff_zero_in = diff_zero_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_drive_in = rsp_drive_ff;
      rsp_clamp_in = rsp_clamp_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_PROP_GAIN:   kp_in    = csr_data;
            CSR_INTEG_GAIN:  ki_in    = csr_data;
            CSR_DERIV_GAIN:  kd_in    = csr_data;
            CSR_DRIVE_LIMIT: limit_in = csr_data[LIMIT_W-1:0];
            CSR_STEP_TIME:   step_in  = csr_data[STEP_W-1:0];
            default: begin
            end
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser[0] == OP_CLEAR) begin
                  last_err_in = '0;
                  integ_in    = '0;
               end else begin
                  err_in   = req_tdata;
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            diff_neg_in  = diff[DATA_W];
            diff_zero_in = (diff == '0);
            last_err_in  = err_ff;
            state_in     = S_WAIT_INT;
         end
         S_WAIT_INT: begin
            if (int_done) begin
               state_in = S_INTEG;
            end
         end
         S_INTEG: begin
            integ_old_in = integ_ff;
            integ_in     = integ_next;
            state_in     = S_WAIT_DIV;
         end
         S_WAIT_DIV: begin
            if (div_done) begin
               state_in = S_DERIV;
            end
         end
         S_DERIV: begin
            state_in = S_WAIT_MUL;
         end
         S_WAIT_MUL: begin
            if (p_done && i_done && d_done) begin
               state_in = S_SUM_A;
            end
         end
         S_SUM_A: begin
            sum_in   = {{(SUM_W - PT_W){p_term[PT_W-1]}}, p_term}
                     + {{(SUM_W - PT_W){d_term[PT_W-1]}}, d_term};
            state_in = S_SUM_B;
         end
         S_SUM_B: begin
            sum_in   = sum_ff + {{(SUM_W - IT_W){i_term[IT_W-1]}}, i_term};
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if ($signed(sum_ff) > $signed(lim_pos)) begin
                  rsp_drive_in = drive_hi;
                  rsp_clamp_in = CLAMP_HIGH;
                  integ_in     = integ_old_ff;
               end else if ($signed(sum_ff) < $signed(lim_neg)) begin
                  rsp_drive_in = -drive_hi;
                  rsp_clamp_in = CLAMP_LOW;
                  integ_in     = integ_old_ff;
               end else begin
                  rsp_drive_in = sum_ff[DATA_W+DRIVE_SHIFT-1:DRIVE_SHIFT];
                  rsp_clamp_in = CLAMP_NONE;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      err_ff       <= err_in;
      integ_old_ff <= integ_old_in;
      diff_neg_ff  <= diff_neg_in;
      diff_zero_ff <= diff_zero_in;
      sum_ff       <= sum_in;
      rsp_drive_ff <= rsp_drive_in;
      rsp_clamp_ff <= rsp_clamp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         kp_ff        <= PROP_GAIN_RST;
         ki_ff        <= INTEG_GAIN_RST;
         kd_ff        <= DERIV_GAIN_RST;
         limit_ff     <= DRIVE_LIMIT_RST;
         step_ff      <= STEP_TIME_RST;
         last_err_ff  <= '0;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         limit_ff     <= limit_in;
         step_ff      <= step_in;
         last_err_ff  <= last_err_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_drive_ff;
   assign rsp_tuser  = rsp_clamp_ff;
   assign csr_ready  = 1'b1;

endmodule

// ----- rtl/pwa_checker.sv -----
module pwa_checker import pwa_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [0:0]        req_tuser,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic [CS_W-1:0]   rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_busy_after_compute: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser[0] == OP_COMPUTE |=> !req_tready)
      else $error("request taken while a compute transaction is in flight");

   a_clamp_high_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == CLAMP_HIGH |-> !rsp_tdata[DATA_W-1])
      else $error("high clamp with negative drive");

   a_clamp_low_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == CLAMP_LOW |-> rsp_tdata[DATA_W-1] || rsp_tdata == '0)
      else $error("low clamp with positive drive");

endmodule

bind pid_with_antiwindup pwa_checker u_pwa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
